// ----- src/cnpm_pkg.sv -----
// Shared types and constants for the cone nearest point mapper.
package cnpm_pkg;

    localparam int IDX_BITS   = 12;
    localparam int COUNT_BITS = 13;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_MAP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic vld;
    } t_eval_ctl;

    typedef struct packed {
        logic busy;
        logic found;
    } t_eval_sts;

endpackage

// ----- src/cnpm_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module cnpm_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/cnpm_eval.sv -----
// Point evaluation pipeline: cone test, perpendicular measure and running minimum.
module cnpm_eval #(
    parameter int COORD_BITS = 24,
    parameter int ADDR_W     = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cnpm_pkg::t_eval_ctl          i_ctl,
    input  logic [ADDR_W-1:0]            i_idx,
    input  logic [3*COORD_BITS-1:0]      i_pt,
    input  logic signed [COORD_BITS-1:0] i_rx,
    input  logic signed [COORD_BITS-1:0] i_ry,
    input  logic signed [COORD_BITS-1:0] i_rz,
    output cnpm_pkg::t_eval_sts          o_sts,
    output logic [ADDR_W-1:0]            o_best_idx
);

    localparam int C  = COORD_BITS;
    localparam int NW = 2 * COORD_BITS;
    localparam int PW = 4 * COORD_BITS;

    logic signed [C-1:0] w_px, w_py, w_pz;

    // vertex norm, continuously derived from the held vertex
    logic signed [NW-1:0] r_rsq_x, r_rsq_y, r_rsq_z;
    logic [NW-1:0]        r_r2;
    logic                 r_r2_zero;

    // stage A: squares and component products
    logic                 r_a_vld;
    logic [ADDR_W-1:0]    r_a_idx;
    logic signed [NW-1:0] r_a_sx, r_a_sy, r_a_sz;
    logic signed [NW-1:0] r_a_mx, r_a_my, r_a_mz;

    // stage B: norm and inner product
    logic                 r_b_vld;
    logic [ADDR_W-1:0]    r_b_idx;
    logic [NW-1:0]        r_b_p2;
    logic [NW-1:0]        r_b_inner;
    logic                 r_b_ok;
    logic                 r_b_pz;
    logic [NW-1:0]        n_p2;
    logic signed [NW+1:0] n_inner;

    // stage C: partial products
    logic                 r_c_vld;
    logic [ADDR_W-1:0]    r_c_idx;
    logic                 r_c_ok;
    logic                 r_c_pz;
    logic [NW-1:0]        r_c_hh, r_c_hl, r_c_lh, r_c_ll;
    logic [NW-1:0]        r_c_ihh, r_c_ihl, r_c_ill;

    // stage D: full products
    logic                 r_d_vld;
    logic [ADDR_W-1:0]    r_d_idx;
    logic                 r_d_ok;
    logic                 r_d_pz;
    logic [PW-1:0]        r_d_prod, r_d_in2;

    // stage E: cone test and distance
    logic                 r_e_vld;
    logic [ADDR_W-1:0]    r_e_idx;
    logic                 r_e_pass;
    logic [PW-1:0]        r_e_dist;

    // best so far
    logic                 r_found;
    logic [PW-1:0]        r_dmin;
    logic [ADDR_W-1:0]    r_best_idx;

    assign w_px = i_pt[0 +: C];
    assign w_py = i_pt[C +: C];
    assign w_pz = i_pt[2*C +: C];

    always_ff @(posedge i_clk) begin
        r_rsq_x   <= i_rx * i_rx;
        r_rsq_y   <= i_ry * i_ry;
        r_rsq_z   <= i_rz * i_rz;
        r_r2      <= $unsigned(r_rsq_x) + $unsigned(r_rsq_y) + $unsigned(r_rsq_z);
        r_r2_zero <= (r_rsq_x == '0) && (r_rsq_y == '0) && (r_rsq_z == '0);
    end

    assign n_p2    = $unsigned(r_a_sx) + $unsigned(r_a_sy) + $unsigned(r_a_sz);
    assign n_inner = (NW+2)'(r_a_mx) + (NW+2)'(r_a_my) + (NW+2)'(r_a_mz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else begin
            r_a_vld <= i_ctl.vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_idx <= i_idx;
        r_a_sx  <= w_px * w_px;
        r_a_sy  <= w_py * w_py;
        r_a_sz  <= w_pz * w_pz;
        r_a_mx  <= i_rx * w_px;
        r_a_my  <= i_ry * w_py;
        r_a_mz  <= i_rz * w_pz;

        r_b_idx   <= r_a_idx;
        r_b_p2    <= n_p2;
        r_b_inner <= n_inner[NW-1:0];
        r_b_ok    <= !n_inner[NW+1];
        r_b_pz    <= (n_p2 == '0);

        r_c_idx <= r_b_idx;
        r_c_ok  <= r_b_ok;
        r_c_pz  <= r_b_pz;
        r_c_hh  <= r_r2[NW-1:C] * r_b_p2[NW-1:C];
        r_c_hl  <= r_r2[NW-1:C] * r_b_p2[C-1:0];
        r_c_lh  <= r_r2[C-1:0] * r_b_p2[NW-1:C];
        r_c_ll  <= r_r2[C-1:0] * r_b_p2[C-1:0];
        r_c_ihh <= r_b_inner[NW-1:C] * r_b_inner[NW-1:C];
        r_c_ihl <= r_b_inner[NW-1:C] * r_b_inner[C-1:0];
        r_c_ill <= r_b_inner[C-1:0] * r_b_inner[C-1:0];

        r_d_idx  <= r_c_idx;
        r_d_ok   <= r_c_ok;
        r_d_pz   <= r_c_pz;
        r_d_prod <= (PW'(r_c_hh) << NW) + ((PW'(r_c_hl) + PW'(r_c_lh)) << C) + PW'(r_c_ll);
        r_d_in2  <= (PW'(r_c_ihh) << NW) + (PW'(r_c_ihl) << (C + 1)) + PW'(r_c_ill);

        r_e_idx  <= r_d_idx;
        r_e_pass <= r_d_ok && !r_d_pz && !r_r2_zero
                    && ({r_d_in2, 1'b0} >= {1'b0, r_d_prod});
        r_e_dist <= r_d_prod - r_d_in2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (r_e_vld && r_e_pass) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_e_vld && r_e_pass && (!r_found || (r_e_dist < r_dmin))) begin
            r_dmin     <= r_e_dist;
            r_best_idx <= r_e_idx;
        end
    end

    assign o_sts.busy  = i_ctl.vld || r_a_vld || r_b_vld || r_c_vld || r_d_vld || r_e_vld;
    assign o_sts.found = r_found;
    assign o_best_idx  = r_best_idx;

endmodule

// ----- src/cone_nearest_point_mapper.sv -----
// Top level: point store, scan sequencer and result register of the cone mapper.
// Load item: written into the point store on acceptance; loads stream one per cycle while no map is in progress.
// Map item: n = min(point_count, POINT_SLOTS) reads, one per cycle, then the pipeline drains;
//   a mapped result first fetches the chosen point, and the result register waits only while a held
//   result waits. The next item is taken the cycle after the result register loads.
// Reset (synchronous, active low) clears control state and point_count, not the point store.
module cone_nearest_point_mapper #(
    parameter int POINT_SLOTS = 4096,
    parameter int COORD_BITS  = 24,
    localparam int S_DATA_W = ((cnpm_pkg::IDX_BITS + 3 * COORD_BITS + 7) / 8) * 8,
    localparam int M_DATA_W = ((cnpm_pkg::IDX_BITS + 3 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [cnpm_pkg::COUNT_BITS-1:0] i_cfg_wr_data,  // point_count
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [S_DATA_W-1:0]             i_s_tdata,      // point_index, pos_x, pos_y, pos_z
    input  logic [0:0]                      i_s_tuser,      // req_type
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [M_DATA_W-1:0]             o_m_tdata,      // mapped_x, mapped_y, mapped_z,
                                                            // chosen_index
    output logic [0:0]                      o_m_tuser       // was_mapped
);

    localparam int C      = COORD_BITS;
    localparam int IB     = cnpm_pkg::IDX_BITS;
    localparam int ADDR_W = (POINT_SLOTS > 1) ? $clog2(POINT_SLOTS) : 1;
    localparam int CNT_W  = ($clog2(POINT_SLOTS + 1) > cnpm_pkg::COUNT_BITS)
                            ? $clog2(POINT_SLOTS + 1) : cnpm_pkg::COUNT_BITS;

    cnpm_pkg::t_state r_state, n_state;

    logic [cnpm_pkg::COUNT_BITS-1:0] r_point_count;
    logic [CNT_W-1:0]                r_scan_n;
    logic [CNT_W-1:0]                r_scan_i;
    logic signed [C-1:0]             r_vx, r_vy, r_vz;
    logic                            r_rd_vld;
    logic [ADDR_W-1:0]               r_rd_idx;
    logic                            r_out_vld;
    logic [M_DATA_W-1:0]             r_out_data;
    logic                            r_out_mapped;

    logic                    w_in_acc;
    logic                    w_map_acc;
    logic                    w_load_we;
    logic                    w_scan_rd;
    logic                    w_fetch_rd;
    logic                    w_out_load;
    logic [IB-1:0]           w_in_idx;
    logic [3*C-1:0]          w_in_pos;
    logic [ADDR_W-1:0]       w_raddr;
    logic [3*C-1:0]          w_rdata;
    logic [ADDR_W-1:0]       w_best_idx;
    cnpm_pkg::t_eval_ctl     w_ctl;
    cnpm_pkg::t_eval_sts     w_sts;

    assign w_in_idx  = i_s_tdata[0 +: IB];
    assign w_in_pos  = i_s_tdata[IB +: 3*C];
    assign w_in_acc  = i_s_tvalid && o_s_tready;
    assign w_map_acc = w_in_acc && (i_s_tuser[0] == cnpm_pkg::REQ_MAP);
    assign w_load_we = w_in_acc && (i_s_tuser[0] == cnpm_pkg::REQ_LOAD)
                       && (32'(w_in_idx) < 32'(POINT_SLOTS));

    always_comb begin
        n_state = r_state;
        case (r_state)
            cnpm_pkg::ST_IDLE: begin
                if (w_map_acc) begin
                    n_state = cnpm_pkg::ST_SCAN;
                end
            end
            cnpm_pkg::ST_SCAN: begin
                if (r_scan_i == r_scan_n) begin
                    n_state = cnpm_pkg::ST_DRAIN;
                end
            end
            cnpm_pkg::ST_DRAIN: begin
                if (!w_sts.busy) begin
                    n_state = w_sts.found ? cnpm_pkg::ST_FETCH : cnpm_pkg::ST_DONE;
                end
            end
            cnpm_pkg::ST_FETCH: begin
                n_state = cnpm_pkg::ST_DONE;
            end
            cnpm_pkg::ST_DONE: begin
                if (!r_out_vld || i_m_tready) begin
                    n_state = cnpm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cnpm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        w_scan_rd  = 1'b0;
        w_fetch_rd = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            cnpm_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
            end
            cnpm_pkg::ST_SCAN: begin
                w_scan_rd = (r_scan_i != r_scan_n);
            end
            cnpm_pkg::ST_FETCH: begin
                w_fetch_rd = 1'b1;
            end
            cnpm_pkg::ST_DONE: begin
                w_out_load = !r_out_vld || i_m_tready;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= cnpm_pkg::ST_IDLE;
            r_point_count <= '0;
            r_rd_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_scan_rd;
            if (i_cfg_wr_en) begin
                r_point_count <= i_cfg_wr_data;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_map_acc) begin
            r_vx     <= w_in_pos[0 +: C];
            r_vy     <= w_in_pos[C +: C];
            r_vz     <= w_in_pos[2*C +: C];
            r_scan_i <= '0;
            r_scan_n <= (32'(r_point_count) < 32'(POINT_SLOTS))
                        ? CNT_W'(r_point_count) : CNT_W'(POINT_SLOTS);
        end else if (w_scan_rd) begin
            r_scan_i <= r_scan_i + 1'b1;
        end
        if (w_scan_rd) begin
            r_rd_idx <= r_scan_i[ADDR_W-1:0];
        end
        if (w_out_load) begin
            r_out_mapped <= w_sts.found;
            if (w_sts.found) begin
                r_out_data <= M_DATA_W'({IB'(w_best_idx), w_rdata});
            end else begin
                r_out_data <= M_DATA_W'({{IB{1'b0}}, r_vz, r_vy, r_vx});
            end
        end
    end

    assign w_raddr   = w_fetch_rd ? w_best_idx : r_scan_i[ADDR_W-1:0];
    assign w_ctl.vld   = r_rd_vld;
    assign w_ctl.clear = w_map_acc;

    cnpm_ram #(
        .WIDTH (3 * C),
        .DEPTH (POINT_SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (ADDR_W'(w_in_idx)),
        .i_wdata (w_in_pos),
        .i_re    (w_scan_rd || w_fetch_rd),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    cnpm_eval #(
        .COORD_BITS (C),
        .ADDR_W     (ADDR_W)
    ) u_eval (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_idx      (r_rd_idx),
        .i_pt       (w_rdata),
        .i_rx       (r_vx),
        .i_ry       (r_vy),
        .i_rz       (r_vz),
        .o_sts      (w_sts),
        .o_best_idx (w_best_idx)
    );

    assign o_m_tvalid   = r_out_vld;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_mapped;

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state) == cnpm_pkg::ST_DONE)
        else $error("result raised outside completion");

    a_unmapped_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[3*C +: IB] == '0))
        else $error("unmapped result carries nonzero index");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cnpm_pkg::ST_SCAN) |-> (r_scan_i <= r_scan_n))
        else $error("scan index past point count");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cnpm_pkg::ST_IDLE) |-> !w_sts.busy)
        else $error("evaluation pipeline active while idle");

endmodule

// ----- tb/tb_cone_nearest_point_mapper.sv -----
// Self-checking testbench for the cone nearest point mapper: loads, vertex maps, point counts.
module tb_cone_nearest_point_mapper;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS          = 4096;
    localparam int COORD_W        = 24;
    localparam int IB             = cnpm_pkg::IDX_BITS;
    localparam int CB             = cnpm_pkg::COUNT_BITS;
    localparam int S_DATA_W       = ((IB + 3 * COORD_W + 7) / 8) * 8;
    localparam int M_DATA_W       = ((IB + 3 * COORD_W + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 12;
    localparam logic signed [COORD_W-1:0] UNIT   = 24'sh010000;  // 1.0 nm in Q7.16
    localparam logic signed [COORD_W-1:0] UNIT_P = 24'sh010001;
    localparam logic signed [COORD_W-1:0] UNIT_2 = 24'sh020000;
    localparam logic signed [COORD_W-1:0] C_MAX  = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] C_MIN  = 24'sh800000;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      mapped;
        logic [IB-1:0]             slot;
    } t_mapping;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CB-1:0]         i_cfg_wr_data = '0;
    logic                  i_s_tvalid    = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata     = '0;  // point_index, pos_x, pos_y, pos_z
    logic [0:0]            i_s_tuser     = '0;  // req_type
    logic                  o_m_tvalid;
    logic                  i_m_tready    = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;            // mapped_x, mapped_y, mapped_z, chosen_index
    logic [0:0]            o_m_tuser;            // was_mapped

    cone_nearest_point_mapper dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser)
    );

    logic signed [COORD_W-1:0] surface_x [SLOTS];
    logic signed [COORD_W-1:0] surface_y [SLOTS];
    logic signed [COORD_W-1:0] surface_z [SLOTS];
    bit                        slot_loaded [SLOTS];
    int                        loaded_prefix = 0;
    int                        point_count_model = 0;
    int                        max_count_used = 0;
    t_mapping                  pending_maps [$];

    bit idle_on = 1'b1;
    int error_count = 0;
    int loads_sent = 0;
    int maps_sent = 0;
    int results_checked = 0;
    int quiet_cycles = 0;
    int stall_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_mapping nearest_in_cone(input logic signed [COORD_W-1:0] vx, vy, vz);
        t_mapping     res;
        longint       rx, ry, rz, px, py, pz, inner;
        logic [127:0] r2, p2, prod, in2, perp_dist, best_dist;
        int           span;
        bit           found;
        res.x = vx;
        res.y = vy;
        res.z = vz;
        res.mapped = 1'b0;
        res.slot = '0;
        rx = vx;
        ry = vy;
        rz = vz;
        r2 = rx * rx + ry * ry + rz * rz;
        span = point_count_model < SLOTS ? point_count_model : SLOTS;
        found = 1'b0;
        best_dist = '0;
        if (r2 == 0)
            return res;
        for (int i = 0; i < span; i++) begin
            px = surface_x[i];
            py = surface_y[i];
            pz = surface_z[i];
            p2 = px * px + py * py + pz * pz;
            if (p2 == 0)
                continue;
            inner = rx * px + ry * py + rz * pz;
            if (inner < 0)
                continue;
            prod = r2 * p2;
            in2 = inner * inner;
            if ((in2 << 1) < prod)
                continue;
            perp_dist = prod - in2;
            if (!found || perp_dist < best_dist) begin
                found = 1'b1;
                best_dist = perp_dist;
                res.x = surface_x[i];
                res.y = surface_y[i];
                res.z = surface_z[i];
                res.mapped = 1'b1;
                res.slot = IB'(i);
            end
        end
        return res;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_small(input int range);
        int v;
        v = int'($urandom_range(0, 2 * range)) - range;
        return COORD_W'(v);
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        if ($urandom_range(0, 2) == 0)
            return COORD_W'($urandom);
        return rand_small(1 << 18);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_item(input logic req, input logic [IB-1:0] slot,
                             input logic signed [COORD_W-1:0] x, y, z);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= {4'b0, z, y, x, slot};
        do @(posedge i_clk); while (!o_s_tready);
        if (req == cnpm_pkg::REQ_LOAD) begin
            surface_x[slot] = x;
            surface_y[slot] = y;
            surface_z[slot] = z;
            slot_loaded[slot] = 1'b1;
            while (loaded_prefix < SLOTS && slot_loaded[loaded_prefix])
                loaded_prefix++;
            loads_sent++;
        end else begin
            pending_maps.insert(pending_maps.size(), nearest_in_cone(x, y, z));
            maps_sent++;
        end
    endtask

    task automatic map_vertex(input logic signed [COORD_W-1:0] x, y, z);
        send_item(cnpm_pkg::REQ_MAP, IB'($urandom), x, y, z);
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_maps.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_point_count(input int value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= CB'(value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        point_count_model = value;
        if (value > max_count_used)
            max_count_used = value;
    endtask

    // Hand-placed dots: zero dot, opposite dot, 45 degree boundary, tie, just outside, extremes.
    task automatic test_cone_geometry();
        set_point_count(0);
        send_item(cnpm_pkg::REQ_LOAD, 12'd0, 24'sd0, 24'sd0, 24'sd0);
        send_item(cnpm_pkg::REQ_LOAD, 12'd1, -24'sd1, 24'sd0, 24'sd0);
        send_item(cnpm_pkg::REQ_LOAD, 12'd2, UNIT, UNIT, 24'sd0);
        send_item(cnpm_pkg::REQ_LOAD, 12'd3, UNIT, UNIT, 24'sd0);
        send_item(cnpm_pkg::REQ_LOAD, 12'd4, UNIT, UNIT_P, 24'sd0);
        send_item(cnpm_pkg::REQ_LOAD, 12'd5, C_MAX, C_MAX, C_MAX);
        send_item(cnpm_pkg::REQ_LOAD, 12'd6, C_MIN, C_MIN, C_MIN);
        send_item(cnpm_pkg::REQ_LOAD, 12'd7, UNIT_2, 24'sd0, UNIT);
        send_item(cnpm_pkg::REQ_LOAD, 12'd4095, C_MIN, C_MAX, C_MIN);
        map_vertex(UNIT, 24'sd0, 24'sd0);
        wait_idle();
        set_point_count(8);
        map_vertex(24'sd0, 24'sd0, 24'sd0);
        map_vertex(UNIT, 24'sd0, 24'sd0);
        map_vertex(-UNIT, 24'sd0, 24'sd0);
        map_vertex(24'sd1, 24'sd1, 24'sd1);
        map_vertex(C_MIN, C_MIN, C_MIN);
        map_vertex(C_MAX, C_MIN, 24'sd0);
        map_vertex(24'sd0, 24'sd0, C_MAX);
        wait_idle();
    endtask

    // Mixed loads and maps in several phases, each with its own point count.
    task automatic test_random_traffic();
        int                        src;
        logic [IB-1:0]             slot;
        logic signed [COORD_W-1:0] vx, vy, vz;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_point_count(1);
                2: set_point_count(loaded_prefix);
                default: set_point_count($urandom_range(1, loaded_prefix));
            endcase
            for (int n = 0; n < 28; n++) begin
                if ($urandom_range(0, 9) < 4) begin
                    slot = $urandom_range(0, 9) == 0 ? IB'($urandom)
                                                      : IB'($urandom_range(0, 63));
                    send_item(cnpm_pkg::REQ_LOAD, slot, rand_coord(), rand_coord(),
                              rand_coord());
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: begin
                            src = $urandom_range(0, loaded_prefix - 1);
                            vx = (surface_x[src] >>> 1) + rand_small(4096);
                            vy = (surface_y[src] >>> 1) + rand_small(4096);
                            vz = (surface_z[src] >>> 1) + rand_small(4096);
                        end
                        5, 6, 7: begin
                            vx = COORD_W'($urandom);
                            vy = COORD_W'($urandom);
                            vz = COORD_W'($urandom);
                        end
                        default: begin
                            vx = rand_small(1 << 10);
                            vy = rand_small(1 << 10);
                            vz = rand_small(1 << 10);
                        end
                    endcase
                    map_vertex(vx, vy, vz);
                end
            end
            wait_idle();
        end
    endtask

    // Loads and maps back to back with no idling on either side.
    task automatic test_back_to_back();
        int base;
        int src;
        idle_on = 1'b0;
        base = loaded_prefix;
        for (int i = 0; i < 4; i++)
            send_item(cnpm_pkg::REQ_LOAD, IB'(base + i), rand_coord(), rand_coord(),
                      rand_coord());
        wait_idle();
        set_point_count(loaded_prefix);
        for (int n = 0; n < 6; n++) begin
            src = $urandom_range(0, loaded_prefix - 1);
            map_vertex(surface_x[src], surface_y[src] + rand_small(64), surface_z[src]);
        end
        wait_idle();
    endtask

    task automatic check_result();
        t_mapping want;
        if (pending_maps.size() == 0) begin
            report_mismatch("result count", results_checked + 1, maps_sent);
            return;
        end
        want = pending_maps.pop_front();
        results_checked++;
        if ($signed(o_m_tdata[23:0]) !== want.x)
            report_mismatch("mapped_x", $signed(o_m_tdata[23:0]), want.x);
        if ($signed(o_m_tdata[47:24]) !== want.y)
            report_mismatch("mapped_y", $signed(o_m_tdata[47:24]), want.y);
        if ($signed(o_m_tdata[71:48]) !== want.z)
            report_mismatch("mapped_z", $signed(o_m_tdata[71:48]), want.z);
        if (o_m_tuser[0] !== want.mapped)
            report_mismatch("was_mapped", o_m_tuser[0], want.mapped);
        if (o_m_tdata[83:72] !== want.slot)
            report_mismatch("chosen_index", o_m_tdata[83:72], want.slot);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (o_m_tvalid && i_m_tready)
                check_result();
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    initial begin
        wait (i_rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_cone_geometry();
        test_random_traffic();
        test_back_to_back();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d point loads and %0d vertex maps, %0d results checked,",
                 loads_sent, maps_sent, results_checked);
        $display("point counts from 0 to %0d, with and without handshake stalls.",
                 max_count_used);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
